@@ rtl/core/rsfp_pkg.sv @@
// shared types and constants for the range sensor frame parser
package rsfp_pkg;

    localparam logic [7:0] SYNC_BYTE       = 8'h59;
    localparam logic [7:0] SYNC_SUM        = 8'hB2;
    localparam logic [3:0] POS_HUNT        = 4'd0;
    localparam logic [3:0] POS_DIST_LOW    = 4'd2;
    localparam logic [3:0] POS_DIST_HIGH   = 4'd3;
    localparam logic [3:0] POS_CHECKSUM    = 4'd8;
    localparam logic [15:0] BAD_COUNT_MAX  = 16'hFFFF;
    localparam logic PARSE_ENABLE_RESET    = 1'b1;
    localparam int   PADDR_W               = 3;
    localparam logic REG_PARSE_ENABLE      = 1'b0;
    localparam logic KIND_FRAME            = 1'b0;
    localparam logic KIND_RAW              = 1'b1;
    localparam int   M_TDATA_W             = 40;

    typedef struct packed {
        logic        kind;
        logic [15:0] value;
        logic        checksum_ok;
        logic [15:0] bad_frame_count;
    } rsfp_result_t;

endpackage

@@ rtl/core/rsfp_parser.sv @@
// frame state tracking, checksum check and result formation for one byte
module rsfp_parser
    import rsfp_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         step,
    input  logic [7:0]   rx_byte,
    input  logic         parse_enable,
    output logic         has_result,
    output rsfp_result_t result
);

    logic [3:0]  position_reg, position_next;
    logic [7:0]  prev_byte_reg, prev_byte_next;
    logic [7:0]  sum_reg, sum_next;
    logic [7:0]  dist_low_reg, dist_low_next;
    logic [7:0]  dist_high_reg, dist_high_next;
    logic [15:0] bad_count_reg, bad_count_next;
    logic        hunting;
    logic        sum_match;

    assign hunting   = (position_reg < POS_DIST_LOW) || (position_reg > POS_CHECKSUM);
    assign sum_match = (sum_reg == rx_byte);

    always_comb begin
        position_next  = position_reg;
        prev_byte_next = prev_byte_reg;
        sum_next       = sum_reg;
        dist_low_next  = dist_low_reg;
        dist_high_next = dist_high_reg;
        bad_count_next = bad_count_reg;
        has_result     = 1'b0;
        result.kind            = KIND_FRAME;
        result.value           = 16'd0;
        result.checksum_ok     = 1'b1;
        result.bad_frame_count = bad_count_reg;
        if (!parse_enable) begin
            has_result   = 1'b1;
            result.kind  = KIND_RAW;
            result.value = {8'd0, rx_byte};
        end else if (hunting) begin
            position_next  = POS_HUNT;
            prev_byte_next = rx_byte;
            if (rx_byte == SYNC_BYTE && prev_byte_reg == SYNC_BYTE) begin
                position_next = POS_DIST_LOW;
                sum_next      = SYNC_SUM;
            end
        end else if (position_reg != POS_CHECKSUM) begin
            if (position_reg == POS_DIST_LOW) begin
                dist_low_next = rx_byte;
            end
            if (position_reg == POS_DIST_HIGH) begin
                dist_high_next = rx_byte;
            end
            sum_next      = sum_reg + rx_byte;
            position_next = position_reg + 4'd1;
        end else begin
            // checksum byte closes the frame
            position_next  = POS_HUNT;
            prev_byte_next = 8'd0;
            has_result     = 1'b1;
            if (sum_match) begin
                result.value = {dist_high_reg, dist_low_reg};
            end else begin
                result.checksum_ok = 1'b0;
                if (bad_count_reg != BAD_COUNT_MAX) begin
                    bad_count_next = bad_count_reg + 16'd1;
                end
                result.bad_frame_count = bad_count_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            position_reg  <= POS_HUNT;
            prev_byte_reg <= 8'd0;
            sum_reg       <= 8'd0;
            dist_low_reg  <= 8'd0;
            dist_high_reg <= 8'd0;
            bad_count_reg <= 16'd0;
        end else if (step) begin
            position_reg  <= position_next;
            prev_byte_reg <= prev_byte_next;
            sum_reg       <= sum_next;
            dist_low_reg  <= dist_low_next;
            dist_high_reg <= dist_high_next;
            bad_count_reg <= bad_count_next;
        end
    end

endmodule

@@ rtl/core/rsfp_out_reg.sv @@
// result register holding one transaction for the master side
module rsfp_out_reg
    import rsfp_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 load,
    input  rsfp_result_t         result,
    output logic                 free,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic [0:0]           m_tuser
);

    logic         valid_reg;
    rsfp_result_t data_reg;

    assign free     = !valid_reg || m_tready;
    assign m_tvalid = valid_reg;
    assign m_tdata  = {{(M_TDATA_W - 33){1'b0}}, data_reg.bad_frame_count,
                       data_reg.checksum_ok, data_reg.value};
    assign m_tuser  = data_reg.kind;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
        end else if (m_tready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= result;
        end
    end

endmodule

@@ rtl/core/range_sensor_frame_parser.sv @@
// top level of the range sensor frame parser
// usage:
//   bytes from the sensor link enter on the s_ stream channel, one per transaction
//   in parse mode a 9-byte frame (two 0x59 sync bytes, distance, checksum) yields
//   one m_ transaction at its checksum byte; other bytes yield none
//   in raw mode each byte yields one m_ transaction carrying the byte
//   parse_enable is set through the apb port at address 0; write it only while idle (the block does not enforce this)
// timing:
//   a byte is captured in an input register and processed once the result register is
//   free; a byte that has a result loads it into the result register, which drives
//   m_tvalid
//   one byte per cycle is sustained while m_tready is high
// reset:
//   aresetn low clears the valid flags of both registers, the frame state and the bad-frame count;
//   parse mode is on after reset
// stalls:
//   when m_tready is low the result register holds; the input register then holds
//   its byte as well and s_tready drops while both are full
module range_sensor_frame_parser
    import rsfp_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,   // rx_byte
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // value, checksum_ok, bad_frame_count, zero pad
    output logic [0:0]           m_tuser,   // kind
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [PADDR_W-1:0]   paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    logic         in_valid_reg;
    logic [7:0]   in_byte_reg;
    logic         parse_enable_reg;
    logic         out_free;
    logic         step;
    logic         has_result;
    rsfp_result_t result;

    assign step     = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
        end
    end

    // configuration register
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_PARSE_ENABLE) ? {31'd0, parse_enable_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            parse_enable_reg <= PARSE_ENABLE_RESET;
        end else if (psel && penable && pwrite && pready && paddr[2] == REG_PARSE_ENABLE) begin
            parse_enable_reg <= pwdata[0];
        end
    end

    rsfp_parser u_parser (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .step         (step),
        .rx_byte      (in_byte_reg),
        .parse_enable (parse_enable_reg),
        .has_result   (has_result),
        .result       (result)
    );

    rsfp_out_reg u_out_reg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (step && has_result),
        .result   (result),
        .free     (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

@@ sim/tb_top.sv @@
// testbench for the range sensor frame parser: stream stimulus, apb setup, self-checking scoreboard
`timescale 1ns / 1ps

module tb_top;
    import rsfp_pkg::*;

    localparam int REG_UNUSED_INDEX = 1;
    localparam logic [PADDR_W-1:0] ADDR_PARSE_ENABLE = PADDR_W'(int'(REG_PARSE_ENABLE) * 4);
    localparam logic [PADDR_W-1:0] ADDR_UNUSED       = PADDR_W'(REG_UNUSED_INDEX * 4);
    localparam int RANDOM_ITEMS   = 400;
    localparam int DRAIN_CYCLES   = 8;
    localparam int MAX_REPORTS    = 100;

    class frame_scoreboard;
        bit           parse_on;
        logic [3:0]   position;
        logic [7:0]   prev_byte;
        logic [7:0]   frame_sum;
        logic [7:0]   dist_lo;
        logic [7:0]   dist_hi;
        logic [15:0]  bad_count;
        rsfp_result_t expected_q[$];
        int           errors;

        function new();
            parse_on  = PARSE_ENABLE_RESET;
            position  = POS_HUNT;
            prev_byte = '0;
            frame_sum = '0;
            dist_lo   = '0;
            dist_hi   = '0;
            bad_count = '0;
            errors    = 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        task report(string msg);
            if (errors < MAX_REPORTS)
                $display("ERROR at %0t: %s", $time, msg);
            errors++;
        endtask

        function void note_byte(logic [7:0] b);
            rsfp_result_t r;
            if (!parse_on) begin
                r.kind            = KIND_RAW;
                r.value           = {8'h00, b};
                r.checksum_ok     = 1'b1;
                r.bad_frame_count = bad_count;
                expected_q.push_back(r);
                return;
            end
            if (position < POS_DIST_LOW || position > POS_CHECKSUM) begin
                position = POS_HUNT;
                if (b == SYNC_BYTE && prev_byte == SYNC_BYTE) begin
                    position  = POS_DIST_LOW;
                    frame_sum = SYNC_SUM;
                end
                prev_byte = b;
                return;
            end
            if (position < POS_CHECKSUM) begin
                if (position == POS_DIST_LOW)
                    dist_lo = b;
                else if (position == POS_DIST_HIGH)
                    dist_hi = b;
                frame_sum = frame_sum + b;
                position  = position + 4'd1;
                return;
            end
            position  = POS_HUNT;
            prev_byte = '0;
            r.kind    = KIND_FRAME;
            if (frame_sum == b) begin
                r.value       = {dist_hi, dist_lo};
                r.checksum_ok = 1'b1;
            end else begin
                if (bad_count != BAD_COUNT_MAX)
                    bad_count = bad_count + 16'd1;
                r.value       = '0;
                r.checksum_ok = 1'b0;
            end
            r.bad_frame_count = bad_count;
            expected_q.push_back(r);
        endfunction

        task check_result(rsfp_result_t got);
            rsfp_result_t want;
            if (expected_q.size() == 0) begin
                report($sformatf("unexpected result kind=%0d value=%h ok=%0d count=%0d",
                                 got.kind, got.value, got.checksum_ok, got.bad_frame_count));
                return;
            end
            want = expected_q.pop_front();
            if (got.kind !== want.kind)
                report($sformatf("kind got %0d want %0d", got.kind, want.kind));
            if (got.value !== want.value)
                report($sformatf("value got %h want %h", got.value, want.value));
            if (got.checksum_ok !== want.checksum_ok)
                report($sformatf("checksum_ok got %0d want %0d",
                                 got.checksum_ok, want.checksum_ok));
            if (got.bad_frame_count !== want.bad_frame_count)
                report($sformatf("bad_frame_count got %0d want %0d",
                                 got.bad_frame_count, want.bad_frame_count));
        endtask
    endclass

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [7:0]           s_tdata;    // rx_byte
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;    // value, checksum_ok, bad_frame_count, zero pad
    logic [0:0]           m_tuser;    // kind
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [PADDR_W-1:0]   paddr;
    logic [31:0]          pwdata;
    logic [31:0]          prdata;
    logic                 pready;

    frame_scoreboard sb;
    rsfp_result_t    mon_result;
    bit              tx_idle_on;
    bit              rx_idle_on;
    int              sent_count;
    int              stall_left;

    range_sensor_frame_parser dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #50_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    function automatic int pick_gap(bit on);
        int r;
        if (!on)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // result side: random backpressure
    initial begin
        m_tready   = 1'b0;
        stall_left = 0;
        forever begin
            @(negedge aclk);
            if (!rx_idle_on)
                stall_left = 0;
            if (stall_left > 0) begin
                m_tready = 1'b0;
                stall_left--;
            end else begin
                m_tready = 1'b1;
                if (rx_idle_on && $urandom_range(0, 4) == 0)
                    stall_left = pick_gap(1'b1);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            mon_result.kind            = m_tuser[0];
            mon_result.value           = m_tdata[15:0];
            mon_result.checksum_ok     = m_tdata[16];
            mon_result.bad_frame_count = m_tdata[32:17];
            sb.check_result(mon_result);
        end
    end

    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = pick_gap(tx_idle_on);
        repeat (gap) @(negedge aclk);
        s_tvalid = 1'b1;
        s_tdata  = b;
        do @(posedge aclk); while (!s_tready);
        sb.note_byte(b);
        sent_count++;
        @(negedge aclk);
        s_tvalid = 1'b0;
    endtask

    task automatic send_frame(input logic [7:0] lo, input logic [7:0] hi, input bit good,
                              input int length);
        logic [7:0] frame_bytes[9];
        logic [7:0] sum;
        int         i;
        frame_bytes[0] = SYNC_BYTE;
        frame_bytes[1] = SYNC_BYTE;
        frame_bytes[2] = lo;
        frame_bytes[3] = hi;
        for (i = 4; i < 8; i++)
            frame_bytes[i] = 8'($urandom);
        sum = '0;
        for (i = 0; i < 8; i++)
            sum = sum + frame_bytes[i];
        frame_bytes[8] = good ? sum : sum + 8'($urandom_range(1, 255));
        for (i = 0; i < length; i++)
            send_byte(frame_bytes[i]);
    endtask

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 3))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic wait_idle();
        while (sb.pending() != 0)
            @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [31:0] data);
        @(negedge aclk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = addr;
        pwdata  = data;
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        if (addr == ADDR_PARSE_ENABLE)
            sb.parse_on = data[0];
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic apb_read_check(input logic [PADDR_W-1:0] addr);
        @(negedge aclk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = addr;
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata !== {31'b0, sb.parse_on})
            sb.report($sformatf("parse_enable read got %h want %0d", prdata, sb.parse_on));
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    initial begin
        int  target;
        int  pick;
        int  n;
        bit  mode;

        sb         = new();
        aresetn    = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        sent_count = 0;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed: hunting noise, max-distance good frame, bad frame, partial frame, raw bytes
        apb_read_check(ADDR_PARSE_ENABLE);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_frame(8'hFF, 8'hFF, 1'b1, 9);
        send_frame(8'h00, 8'h00, 1'b0, 9);
        send_frame(8'h34, 8'h12, 1'b1, 5);
        wait_idle();
        apb_write(ADDR_PARSE_ENABLE, 32'hFFFF_FFFE);
        apb_read_check(ADDR_PARSE_ENABLE);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(SYNC_BYTE);
        wait_idle();
        apb_write(ADDR_UNUSED, 32'hFFFF_FFFF);
        send_byte(8'hA5);
        wait_idle();
        // resume the partial frame where it stopped
        apb_write(ADDR_PARSE_ENABLE, 32'hFFFF_FFFF);
        apb_read_check(ADDR_PARSE_ENABLE);
        send_byte(8'h00);
        send_byte(8'h00);
        send_byte(8'h00);
        send_byte(8'h00);

        // random phases
        target = sent_count + RANDOM_ITEMS;
        while (sent_count < target) begin
            wait_idle();
            mode = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 7) == 0)
                apb_write(ADDR_UNUSED, $urandom);
            apb_write(ADDR_PARSE_ENABLE, {31'($urandom_range(0, 32'h7FFF_FFFF)), mode});
            tx_idle_on = ($urandom_range(0, 3) != 0);
            rx_idle_on = ($urandom_range(0, 3) != 0);
            n = sent_count + $urandom_range(20, 70);
            while (sent_count < n) begin
                pick = $urandom_range(0, 99);
                if (pick < 65)
                    send_frame(pick_byte(), pick_byte(), $urandom_range(0, 3) != 0, 9);
                else if (pick < 75)
                    send_frame(pick_byte(), pick_byte(), 1'b1, $urandom_range(1, 8));
                else if (pick < 85)
                    repeat ($urandom_range(1, 3)) send_byte(SYNC_BYTE);
                else
                    repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
            end
        end

        // back-to-back bad frames and a good one at full rate
        wait_idle();
        apb_write(ADDR_PARSE_ENABLE, 32'h0000_0001);
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        repeat (4) send_frame(8'($urandom), 8'($urandom), 1'b0, 9);
        send_frame(8'h78, 8'h56, 1'b1, 9);
        wait_idle();
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        apb_write(ADDR_PARSE_ENABLE, 32'h0000_0000);
        send_byte(8'h5A);
        send_byte(8'hC3);

        s_tvalid = 1'b0;
        wait_idle();
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (sb.errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

@@ files.f @@
rtl/core/rsfp_pkg.sv
rtl/core/rsfp_parser.sv
rtl/core/rsfp_out_reg.sv
rtl/core/range_sensor_frame_parser.sv
sim/tb_top.sv
